// ===== design/u128d_pkg.sv =====
package u128d_pkg;

    localparam int VALUE_BITS = 128;
    localparam int MAX_DIGITS = 39;
    localparam int BCD_BITS   = MAX_DIGITS * 4;
    localparam int BIT_W      = $clog2(VALUE_BITS);
    localparam int LEFT_W     = $clog2(MAX_DIGITS + 1);

    localparam logic [5:0] ASCII_ZERO = 6'd48;
    localparam logic [3:0] DIGIT_ADJ_MIN = 4'd5;
    localparam logic [3:0] DIGIT_ADJ     = 4'd3;

    typedef struct packed {
        logic [63:0] value_high;
        logic [63:0] value_low;
    } t_in_item;

    typedef struct packed {
        logic [5:0] digit_char;
        logic       last_digit;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

endpackage

// ===== design/u128d_dabble_step.sv =====
module u128d_dabble_step
    import u128d_pkg::*;
(
    input  logic [BCD_BITS-1:0] i_bcd,
    input  logic                i_bit,
    output logic [BCD_BITS-1:0] o_bcd
);

    logic [BCD_BITS-1:0] w_adj;

    always_comb begin
        logic [3:0] d;
        for (int k = 0; k < MAX_DIGITS; k++) begin
            d = i_bcd[k*4 +: 4];
            if (d >= DIGIT_ADJ_MIN) begin
                w_adj[k*4 +: 4] = d + DIGIT_ADJ;
            end else begin
                w_adj[k*4 +: 4] = d;
            end
        end
    end

    assign o_bcd = {w_adj[BCD_BITS-2:0], i_bit};

endmodule

// ===== design/u128_to_decimal_digits_unit.sv =====
// An item is taken in the idle cycle, then goes through bit-serial double dabble of all 128 bits
// through one shared add-3 and shift unit, then a pass over the 39 BCD digits that skips leading zeros
// and emits one digit per cycle while the output is not stalled.
// The unit is ready for the next item in the cycle after the last digit is loaded into the output register.
// Reset is synchronous and active low; it clears the sequencer and the output valid flag.
module u128_to_decimal_digits_unit
    import u128d_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    t_state              r_state, n_state;
    logic [VALUE_BITS-1:0] r_bin, n_bin;
    logic [BCD_BITS-1:0] r_bcd, n_bcd;
    logic [BIT_W-1:0]    r_bit, n_bit;
    logic [LEFT_W-1:0]   r_left, n_left;
    logic                r_lead, n_lead;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    logic [BCD_BITS-1:0] w_bcd_step;
    logic [3:0]          w_top;
    logic [127:0]        w_value;

    u128d_dabble_step u_step (
        .i_bcd (r_bcd),
        .i_bit (r_bin[VALUE_BITS-1]),
        .o_bcd (w_bcd_step)
    );

    assign w_top   = r_bcd[BCD_BITS-1 -: 4];
    assign w_value = {i_item.value_high, i_item.value_low};

    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_bit       = r_bit;
        n_left      = r_left;
        n_lead      = r_lead;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_bin   = w_value[VALUE_BITS-1:0];
                    n_bcd   = '0;
                    n_bit   = BIT_W'(VALUE_BITS - 1);
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd = w_bcd_step;
                n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
                if (r_bit == '0) begin
                    n_left  = LEFT_W'(MAX_DIGITS);
                    n_lead  = 1'b1;
                    n_state = ST_EMIT;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            ST_EMIT: begin
                if (r_lead && (w_top == 4'd0) && (r_left != LEFT_W'(1))) begin
                    n_bcd  = {r_bcd[BCD_BITS-5:0], 4'd0};
                    n_left = r_left - 1'b1;
                end else if (!r_out_valid || i_ready) begin
                    n_out_valid      = 1'b1;
                    n_out.digit_char = ASCII_ZERO + {2'b00, w_top};
                    n_out.last_digit = (r_left == LEFT_W'(1));
                    n_bcd            = {r_bcd[BCD_BITS-5:0], 4'd0};
                    n_left           = r_left - 1'b1;
                    n_lead           = 1'b0;
                    if (r_left == LEFT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bit       <= '0;
            r_left      <= '0;
            r_lead      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit       <= n_bit;
            r_left      <= n_left;
            r_lead      <= n_lead;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_out <= n_out;
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    import u128d_pkg::*;

    class decimal_digit_checker;
        t_out_item pending_digits[$];
        int        mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Works out the decimal digits of one accepted value, most significant first.
        function void expand_value(t_in_item it);
            logic [127:0] rest;
            logic [3:0]   digits[$];
            t_out_item    want;
            rest = {it.value_high, it.value_low};
            rest = rest & ((128'(1) << VALUE_BITS) - 128'(1));
            do begin
                digits.push_back(4'(rest % 128'd10));
                rest = rest / 128'd10;
            end while (rest != 0 && digits.size() < MAX_DIGITS);
            for (int k = digits.size() - 1; k >= 0; k--) begin
                want.digit_char = ASCII_ZERO + 6'(digits[k]);
                want.last_digit = (k == 0);
                pending_digits.push_back(want);
            end
        endfunction

        function void match_digit(t_out_item got);
            t_out_item want;
            if (pending_digits.size() == 0) begin
                $error("unexpected digit: digit_char %0d, last_digit %0d",
                       got.digit_char, got.last_digit);
                mismatches++;
                return;
            end
            want = pending_digits.pop_front();
            if (got.digit_char !== want.digit_char) begin
                $error("digit_char: expected %0d, actual %0d", want.digit_char, got.digit_char);
                mismatches++;
            end
            if (got.last_digit !== want.last_digit) begin
                $error("last_digit: expected %0d, actual %0d", want.last_digit, got.last_digit);
                mismatches++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_item;

    bit quiet_tail;
    bit hold_output;

    decimal_digit_checker digit_check = new();

    u128_to_decimal_digits_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_valid && o_ready) begin
                digit_check.expand_value(i_item);
            end
            if (o_valid && i_ready) begin
                digit_check.match_digit(o_item);
            end
        end
    end

    function automatic logic [127:0] power_of_ten(int n);
        logic [127:0] acc;
        acc = 128'd1;
        repeat (n) acc = acc * 128'd10;
        return acc;
    endfunction

    function automatic logic [127:0] random_value();
        logic [127:0] v;
        v = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return v;
            1: return v >> $urandom_range(0, 127);
            2: return 128'($urandom_range(0, 1000));
            3: return power_of_ten($urandom_range(0, 38)) + 128'($urandom_range(0, 2)) - 128'd1;
            4: return {v[127:64], 64'd0};
            default: return {64'd0, v[63:0]};
        endcase
    endfunction

    task automatic send_value(input logic [127:0] v);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= t_in_item'(v);
        do @(posedge i_clk); while (!o_ready);
    endtask

    initial begin
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_output) begin
                hold_output = 1'b0;
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    end

    initial begin
        logic [127:0] directed[$];
        int           wait_cycles;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_item  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed = '{128'd0, 128'd1, 128'd9, 128'd10, 128'd99, 128'd100,
                     {64'd0, {64{1'b1}}}, {64'd1, 64'd0}, {128{1'b1}},
                     power_of_ten(38), power_of_ten(38) - 128'd1,
                     power_of_ten(19), power_of_ten(19) - 128'd1,
                     {{64{1'b1}}, 64'd0}, {64{2'b10}}, {64{2'b01}},
                     {1'b1, 127'd0}, {64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000},
                     128'd1234567890};
        foreach (directed[j]) send_value(directed[j]);

        for (int n = 0; n < 500; n++) begin
            if (n == 100) hold_output = 1'b1;
            if (n == 440) quiet_tail = 1'b1;
            send_value(random_value());
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        wait_cycles = 0;
        while (digit_check.pending_digits.size() != 0 && wait_cycles < 100_000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(posedge i_clk);

        if (digit_check.mismatches == 0 && digit_check.pending_digits.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
